// ===== hdl/tct_pkg.sv =====
// tct_pkg: shared types and constants for the text console teletype core.
// Used by tct_screen_mem, tct_ctrl and text_console_teletype_core.
// No dependencies.
`timescale 1ns / 1ps

package tct_pkg;

	localparam int CMD_W      = 2;
	localparam int CHAR_W     = 8;
	localparam int ATTR_W     = 8;
	localparam int DX_W       = 8;
	localparam int DY_W       = 6;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;
	localparam int TAB_STOP   = 4;
	localparam int TAB_W      = 2;
	localparam int TAB_CNT_W  = 3;

	localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h00;
	localparam logic [ATTR_W-1:0] BLANK_ATTR = 8'h07;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUT   = 2'd0,
		CMD_MOVE  = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FREE_MODE  = 1'b0,
		REG_WRITE_ATTR = 1'b1
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_SWEEP,
		ST_DRAIN,
		ST_IDLE,
		ST_EXEC,
		ST_PUT,
		ST_AFTER,
		ST_BACK,
		ST_READ,
		ST_DONE
	} tct_state_t;

	typedef enum logic [1:0] {
		K_PLAIN,
		K_TAB,
		K_BACK,
		K_INIT
	} put_kind_t;

	typedef struct packed {
		logic chr_we;
		logic attr_we;
		logic rd_en;
	} mem_ctl_t;

endpackage

// ===== hdl/text_console_teletype_core.sv =====
// text_console_teletype_core: top level of the text console; config
// registers, handshake and result register. Depends on tct_pkg,
// tct_ctrl and tct_screen_mem.
//
// Usage: one command word per in_valid/in_ready handshake (put character,
// relative move, clear screen, read cell); one result word per command on
// out_valid/out_ready carrying the cursor and, for read, the cell.
// cfg_we writes free_mode (index 0) or write_attribute (index 1) at once.
// After decode, a move, return or newline goes straight to the result;
// a read first fetches the cell, a plain put writes it, a backspace
// writes a space and then steps the cursor back, and a tab writes 1 to 4
// spaces. A put, tab or backspace that runs off the last row scrolls the
// screen in one pass of the screen store, one cell a cycle; so does a
// newline on the last row. Clear blanks the store in one such pass. A new
// command is taken only once the previous result is registered.
// After reset the screen store is blanked in one pass during which
// in_ready is low; config writes are still taken.
// A stalled receiver holds the result register; the next command is still
// accepted and run, and its result waits until the register is freed.

`timescale 1ns / 1ps

module text_console_teletype_core #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [tct_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [tct_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [tct_pkg::CMD_W-1:0]             command,
	input  logic [tct_pkg::CHAR_W-1:0]            char_code,
	input  logic signed [tct_pkg::DX_W-1:0]       move_dx,
	input  logic signed [tct_pkg::DY_W-1:0]       move_dy,
	input  logic [$clog2(COLUMNS*ROWS)-1:0]       cell_index,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [$clog2(COLUMNS)-1:0]            cursor_col,
	output logic [$clog2(ROWS)-1:0]               cursor_row,
	output logic [$clog2(COLUMNS*ROWS)-1:0]       cursor_pos,
	output logic [tct_pkg::CHAR_W-1:0]            cell_char,
	output logic [tct_pkg::ATTR_W-1:0]            cell_attr
);
	import tct_pkg::*;

	localparam int CELLS = COLUMNS * ROWS;
	localparam int COL_W = $clog2(COLUMNS);
	localparam int ROW_W = $clog2(ROWS);
	localparam int POS_W = $clog2(CELLS);

	logic              free_mode_q;
	logic [ATTR_W-1:0] wattr_q;
	logic              out_valid_q;
	logic [COL_W-1:0]  out_col_q;
	logic [ROW_W-1:0]  out_row_q;
	logic [POS_W-1:0]  out_pos_q;
	logic [CHAR_W-1:0] out_chr_q;
	logic [ATTR_W-1:0] out_attr_q;

	logic              idle;
	logic              out_free;
	logic              res_load;
	logic [COL_W-1:0]  res_col;
	logic [ROW_W-1:0]  res_row;
	logic [POS_W-1:0]  res_pos;
	logic [CHAR_W-1:0] res_chr;
	logic [ATTR_W-1:0] res_attr;
	mem_ctl_t          mem_ctl;
	logic [POS_W-1:0]  mem_waddr;
	logic [CHAR_W-1:0] mem_wchr;
	logic [ATTR_W-1:0] mem_wattr;
	logic [POS_W-1:0]  mem_raddr;
	logic [CHAR_W-1:0] mem_rchr;
	logic [ATTR_W-1:0] mem_rattr;

	assign in_ready = idle;
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_mode_q <= 1'b0;
			wattr_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_FREE_MODE:  free_mode_q <= cfg_data[0];
				REG_WRITE_ATTR: wattr_q     <= cfg_data[ATTR_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_col_q  <= res_col;
			out_row_q  <= res_row;
			out_pos_q  <= res_pos;
			out_chr_q  <= res_chr;
			out_attr_q <= res_attr;
		end
	end

	assign out_valid  = out_valid_q;
	assign cursor_col = out_col_q;
	assign cursor_row = out_row_q;
	assign cursor_pos = out_pos_q;
	assign cell_char  = out_chr_q;
	assign cell_attr  = out_attr_q;

	tct_ctrl #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.free_mode       (free_mode_q),
		.write_attribute (wattr_q),
		.in_fire         (in_valid && idle),
		.command         (command),
		.char_code       (char_code),
		.move_dx         (move_dx),
		.move_dy         (move_dy),
		.cell_index      (cell_index),
		.idle            (idle),
		.out_free        (out_free),
		.res_load        (res_load),
		.res_col         (res_col),
		.res_row         (res_row),
		.res_pos         (res_pos),
		.res_chr         (res_chr),
		.res_attr        (res_attr),
		.mem_ctl         (mem_ctl),
		.mem_waddr       (mem_waddr),
		.mem_wchr        (mem_wchr),
		.mem_wattr       (mem_wattr),
		.mem_raddr       (mem_raddr),
		.mem_rchr        (mem_rchr),
		.mem_rattr       (mem_rattr)
	);

	tct_screen_mem #(
		.DEPTH (CELLS),
		.AW    (POS_W)
	) u_mem (
		.clk   (clk),
		.ctl   (mem_ctl),
		.waddr (mem_waddr),
		.wchr  (mem_wchr),
		.wattr (mem_wattr),
		.raddr (mem_raddr),
		.rchr  (mem_rchr),
		.rattr (mem_rattr)
	);

`ifndef NO_ASSERTIONS
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> out_free)
		else $error("result register overwritten before taken");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("command accepted while sequencer busy");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(cursor_pos)))
		else $error("stalled result changed");
`endif

endmodule

// ===== hdl/tct_screen_mem.sv =====
// tct_screen_mem: character and attribute screen store, one write port and
// one registered read port. Depends on tct_pkg.
`timescale 1ns / 1ps

module tct_screen_mem #(
	parameter int DEPTH = 2000,
	parameter int AW    = 11
) (
	input  logic                          clk,
	input  tct_pkg::mem_ctl_t             ctl,
	input  logic [AW-1:0]                 waddr,
	input  logic [tct_pkg::CHAR_W-1:0]    wchr,
	input  logic [tct_pkg::ATTR_W-1:0]    wattr,
	input  logic [AW-1:0]                 raddr,
	output logic [tct_pkg::CHAR_W-1:0]    rchr,
	output logic [tct_pkg::ATTR_W-1:0]    rattr
);
	import tct_pkg::*;

	logic [CHAR_W-1:0] chr_mem [DEPTH];
	logic [ATTR_W-1:0] attr_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.chr_we) begin
			chr_mem[waddr] <= wchr;
		end
		if (ctl.attr_we) begin
			attr_mem[waddr] <= wattr;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rchr  <= chr_mem[raddr];
			rattr <= attr_mem[raddr];
		end
	end

endmodule

// ===== hdl/tct_ctrl.sv =====
// tct_ctrl: command sequencer, cursor arithmetic and screen sweep engine
// (clear, scroll copy). Depends on tct_pkg; drives tct_screen_mem.
`timescale 1ns / 1ps

module tct_ctrl #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      free_mode,
	input  logic [tct_pkg::ATTR_W-1:0]                write_attribute,
	input  logic                                      in_fire,
	input  logic [tct_pkg::CMD_W-1:0]                 command,
	input  logic [tct_pkg::CHAR_W-1:0]                char_code,
	input  logic signed [tct_pkg::DX_W-1:0]           move_dx,
	input  logic signed [tct_pkg::DY_W-1:0]           move_dy,
	input  logic [$clog2(COLUMNS*ROWS)-1:0]           cell_index,
	output logic                                      idle,
	input  logic                                      out_free,
	output logic                                      res_load,
	output logic [$clog2(COLUMNS)-1:0]                res_col,
	output logic [$clog2(ROWS)-1:0]                   res_row,
	output logic [$clog2(COLUMNS*ROWS)-1:0]           res_pos,
	output logic [tct_pkg::CHAR_W-1:0]                res_chr,
	output logic [tct_pkg::ATTR_W-1:0]                res_attr,
	output tct_pkg::mem_ctl_t                         mem_ctl,
	output logic [$clog2(COLUMNS*ROWS)-1:0]           mem_waddr,
	output logic [tct_pkg::CHAR_W-1:0]                mem_wchr,
	output logic [tct_pkg::ATTR_W-1:0]                mem_wattr,
	output logic [$clog2(COLUMNS*ROWS)-1:0]           mem_raddr,
	input  logic [tct_pkg::CHAR_W-1:0]                mem_rchr,
	input  logic [tct_pkg::ATTR_W-1:0]                mem_rattr
);
	import tct_pkg::*;

	localparam int CELLS = COLUMNS * ROWS;
	localparam int COL_W = $clog2(COLUMNS);
	localparam int ROW_W = $clog2(ROWS);
	localparam int POS_W = $clog2(CELLS);
	localparam int MVC_W = ((COL_W > DX_W - 1) ? COL_W : DX_W - 1) + 2;
	localparam int MVR_W = ((ROW_W > DY_W - 1) ? ROW_W : DY_W - 1) + 2;

	localparam logic [COL_W-1:0] LAST_COL  = COL_W'(COLUMNS - 1);
	localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(ROWS - 1);
	localparam logic [POS_W-1:0] LAST_CELL = POS_W'(CELLS - 1);
	localparam logic [POS_W-1:0] LAST_ROW_BASE = POS_W'(CELLS - COLUMNS);

	tct_state_t state_q, state_d;
	put_kind_t  kind_q;

	logic [COL_W-1:0]     col_q;
	logic [ROW_W-1:0]     row_q;
	logic [POS_W-1:0]     tgt_q;
	logic                 copy_q;
	logic [TAB_CNT_W-1:0] cnt_q;
	logic                 cp_vld_q;
	logic [POS_W-1:0]     cp_addr_q;
	logic                 cp_blank_q;

	logic [CMD_W-1:0]       cmd_q;
	logic [CHAR_W-1:0]      chr_q;
	logic signed [DX_W-1:0] dx_q;
	logic signed [DY_W-1:0] dy_q;
	logic [POS_W-1:0]       idx_q;
	logic [CHAR_W-1:0]      wchr_q;
	logic [CHAR_W-1:0]      res_chr_q;
	logic [ATTR_W-1:0]      res_attr_q;

	logic [POS_W-1:0]        cur_pos;
	logic                    rd_ok;
	logic                    sweep_blank;
	logic                    wrap_scroll;
	logic signed [MVC_W-1:0] mv_col;
	logic signed [MVR_W-1:0] mv_row;
	logic [COL_W-1:0]        col_mv;
	logic [ROW_W-1:0]        row_mv;

	assign cur_pos     = POS_W'(row_q) * POS_W'(COLUMNS) + POS_W'(col_q);
	assign rd_ok       = {1'b0, idx_q} < (POS_W + 1)'(CELLS);
	assign sweep_blank = !copy_q || (tgt_q >= LAST_ROW_BASE);
	assign wrap_scroll = (col_q == LAST_COL) && (row_q == LAST_ROW);

	// relative move with saturation
	always_comb begin
		mv_col = $signed({{(MVC_W - COL_W){1'b0}}, col_q}) + MVC_W'(dx_q);
		mv_row = $signed({{(MVR_W - ROW_W){1'b0}}, row_q}) + MVR_W'(dy_q);
		if (mv_col < 0) begin
			col_mv = '0;
		end else if (mv_col > $signed(MVC_W'(COLUMNS - 1))) begin
			col_mv = LAST_COL;
		end else begin
			col_mv = mv_col[COL_W-1:0];
		end
		if (mv_row < 0) begin
			row_mv = '0;
		end else if (mv_row > $signed(MVR_W'(ROWS - 1))) begin
			row_mv = LAST_ROW;
		end else begin
			row_mv = mv_row[ROW_W-1:0];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_SWEEP: begin
				if (tgt_q == LAST_CELL) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_AFTER;
			ST_IDLE: begin
				if (in_fire) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				case (cmd_t'(cmd_q))
					CMD_PUT: begin
						if (chr_q == CH_LF) begin
							state_d = (row_q == LAST_ROW) ? ST_SWEEP : ST_DONE;
						end else if (chr_q == CH_CR) begin
							state_d = ST_DONE;
						end else begin
							state_d = ST_PUT;
						end
					end
					CMD_CLEAR: state_d = ST_SWEEP;
					CMD_READ:  state_d = ST_READ;
					default:   state_d = ST_DONE;
				endcase
			end
			ST_PUT: state_d = wrap_scroll ? ST_SWEEP : ST_AFTER;
			ST_AFTER: begin
				case (kind_q)
					K_TAB:   state_d = (cnt_q != '0) ? ST_PUT : ST_DONE;
					K_BACK:  state_d = ST_BACK;
					K_INIT:  state_d = ST_IDLE;
					default: state_d = ST_DONE;
				endcase
			end
			ST_BACK: state_d = ST_DONE;
			ST_READ: state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs and memory port
	always_comb begin
		idle      = (state_q == ST_IDLE);
		res_load  = (state_q == ST_DONE) && out_free;
		mem_ctl   = '0;
		mem_waddr = cur_pos;
		mem_wchr  = wchr_q;
		mem_wattr = write_attribute;
		mem_raddr = idx_q;
		if (state_q == ST_SWEEP) begin
			mem_raddr      = tgt_q + POS_W'(COLUMNS);
			mem_ctl.rd_en  = !sweep_blank;
		end else if (state_q == ST_EXEC) begin
			mem_ctl.rd_en  = (cmd_t'(cmd_q) == CMD_READ) && rd_ok;
		end
		if (cp_vld_q) begin
			mem_ctl.chr_we  = 1'b1;
			mem_ctl.attr_we = 1'b1;
			mem_waddr       = cp_addr_q;
			mem_wchr        = cp_blank_q ? BLANK_CHAR : mem_rchr;
			mem_wattr       = cp_blank_q ? BLANK_ATTR : mem_rattr;
		end else if (state_q == ST_PUT) begin
			mem_ctl.chr_we  = 1'b1;
			mem_ctl.attr_we = (write_attribute != '0);
		end
	end

	assign res_col  = col_q;
	assign res_row  = row_q;
	assign res_pos  = cur_pos;
	assign res_chr  = res_chr_q;
	assign res_attr = res_attr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_SWEEP;
			kind_q   <= K_INIT;
			col_q    <= '0;
			row_q    <= '0;
			tgt_q    <= '0;
			copy_q   <= 1'b0;
			cnt_q    <= '0;
			cp_vld_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			cp_vld_q <= (state_q == ST_SWEEP);
			case (state_q)
				ST_SWEEP: tgt_q <= tgt_q + 1'b1;
				ST_EXEC: begin
					tgt_q  <= '0;
					kind_q <= K_PLAIN;
					cnt_q  <= TAB_CNT_W'(TAB_STOP) - {1'b0, col_q[TAB_W-1:0]};
					case (cmd_t'(cmd_q))
						CMD_PUT: begin
							copy_q <= 1'b1;
							if (chr_q == CH_TAB) begin
								kind_q <= K_TAB;
							end else if (chr_q == CH_BS) begin
								kind_q <= K_BACK;
							end
							if (chr_q == CH_LF) begin
								col_q <= '0;
								if (row_q != LAST_ROW) begin
									row_q <= row_q + 1'b1;
								end
							end else if (chr_q == CH_CR) begin
								col_q <= '0;
							end
						end
						CMD_MOVE: begin
							col_q <= col_mv;
							row_q <= row_mv;
						end
						CMD_CLEAR: begin
							copy_q <= 1'b0;
							col_q  <= '0;
							row_q  <= '0;
						end
						default: ;
					endcase
				end
				ST_PUT: begin
					tgt_q  <= '0;
					copy_q <= 1'b1;
					cnt_q  <= cnt_q - 1'b1;
					if (col_q == LAST_COL) begin
						col_q <= '0;
						if (row_q != LAST_ROW) begin
							row_q <= row_q + 1'b1;
						end
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
				ST_BACK: begin
					if (col_q >= COL_W'(2)) begin
						col_q <= col_q - COL_W'(2);
					end else if (free_mode) begin
						col_q <= LAST_COL;
						if (row_q != '0) begin
							row_q <= row_q - 1'b1;
						end
					end else begin
						col_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		cp_addr_q  <= tgt_q;
		cp_blank_q <= sweep_blank;
		if (in_fire && state_q == ST_IDLE) begin
			cmd_q <= command;
			chr_q <= char_code;
			dx_q  <= move_dx;
			dy_q  <= move_dy;
			idx_q <= cell_index;
		end
		if (state_q == ST_EXEC) begin
			wchr_q     <= ((chr_q == CH_TAB) || (chr_q == CH_BS)) ? CH_SPACE : chr_q;
			res_chr_q  <= '0;
			res_attr_q <= '0;
		end
		if (state_q == ST_READ && rd_ok) begin
			res_chr_q  <= mem_rchr;
			res_attr_q <= mem_rattr;
		end
	end

`ifndef NO_ASSERTIONS
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(col_q <= LAST_COL) && (row_q <= LAST_ROW))
		else $error("cursor out of screen");

	a_idle_no_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !cp_vld_q)
		else $error("sweep write pending while idle");

	a_put_no_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PUT) |-> !cp_vld_q)
		else $error("character write collides with sweep write");

	a_tab_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PUT && kind_q == K_TAB) |-> (cnt_q != '0))
		else $error("tab space written with no count left");

	a_sweep_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP) |-> (tgt_q <= LAST_CELL))
		else $error("sweep past end of screen store");
`endif

endmodule
